@@ hw/rtl/ifmt_pkg.sv @@
// ifmt_pkg: request codes, character constants, digit table and control structs
// for the integer to ASCII formatter. No dependencies.
package ifmt_pkg;

    localparam logic [2:0] REQ_HEX32 = 3'd0;
    localparam logic [2:0] REQ_HEX16 = 3'd1;
    localparam logic [2:0] REQ_HEX8  = 3'd2;
    localparam logic [2:0] REQ_DEC   = 3'd3;
    localparam logic [2:0] REQ_RAW   = 3'd4;
    localparam logic [2:0] REQ_QUAD  = 3'd5;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    localparam int BCD_DIGITS = 10;

    localparam logic [5:0] DEC32_BITS   = 6'd32;
    localparam logic [5:0] DEC8_BITS    = 6'd8;
    localparam logic [3:0] DEC32_DIGITS = 4'd10;
    localparam logic [3:0] DEC8_DIGITS  = 4'd3;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic        start;
        logic [31:0] bin;
        logic [5:0]  nbits;
    } bcd_cmd_t;

    typedef struct packed {
        logic       push;
        logic [7:0] ch;
        logic       last;
    } out_push_t;

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return HEX_DIGITS[nib];
    endfunction

endpackage

@@ hw/rtl/ifmt_req_if.sv @@
// ifmt_req_if: request channel, valid/ready with request kind, prefix flag and operand.
// Standalone; no package needed.
interface ifmt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic        alt_prefix;
    logic [31:0] value;

    modport source (output valid, output req_type, output alt_prefix, output value,
                    input ready);
    modport sink   (input valid, input req_type, input alt_prefix, input value,
                    output ready);
endinterface

@@ hw/rtl/ifmt_chr_if.sv @@
// ifmt_chr_if: character channel, valid/ready with one byte and a last flag.
// Standalone; no package needed.
interface ifmt_chr_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_char;
    logic       last_char;

    modport source (output valid, output ascii_char, output last_char, input ready);
    modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

@@ hw/rtl/ifmt_bcd.sv @@
// ifmt_bcd: bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// Depends on ifmt_pkg.
module ifmt_bcd
    import ifmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bcd_cmd_t   cmd,
    input  logic [3:0] sel,
    output logic       busy,
    output logic [3:0] digit
);

    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] bin_reg;
    logic [3:0]  dig_reg [BCD_DIGITS];
    logic [3:0]  adj [BCD_DIGITS];

    assign busy = (cnt_reg != 6'd0);

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            adj[i] = (dig_reg[i] >= 4'd5) ? dig_reg[i] + 4'd3 : dig_reg[i];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.start)
        begin
            cnt_next = cmd.nbits;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            bin_reg <= cmd.bin;
            for (int i = 0; i < BCD_DIGITS; i++)
            begin
                dig_reg[i] <= 4'd0;
            end
        end
        else if (busy)
        begin
            bin_reg    <= {bin_reg[30:0], 1'b0};
            dig_reg[0] <= {adj[0][2:0], bin_reg[31]};
            for (int i = 1; i < BCD_DIGITS; i++)
            begin
                dig_reg[i] <= {adj[i][2:0], adj[i-1][3]};
            end
        end
    end

    assign digit = (sel < DEC32_DIGITS) ? dig_reg[sel] : 4'd0;

endmodule

@@ hw/rtl/ifmt_out_stage.sv @@
// ifmt_out_stage: output register between the sequencer and the character channel.
// Depends on ifmt_pkg and ifmt_chr_if.
module ifmt_out_stage
    import ifmt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  out_push_t       push,
    output logic            free,
    ifmt_chr_if.source      chr
);

    logic       valid_reg;
    logic [7:0] ch_reg;
    logic       last_reg;

    assign free           = !valid_reg || chr.ready;
    assign chr.valid      = valid_reg;
    assign chr.ascii_char = ch_reg;
    assign chr.last_char  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push.push)
        begin
            valid_reg <= 1'b1;
        end
        else if (chr.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            ch_reg   <= push.ch;
            last_reg <= push.last;
        end
    end

endmodule

@@ hw/rtl/integer_to_ascii_formatter_core.sv @@
// integer_to_ascii_formatter_core: request sequencer, hex nibble shifter and decimal digit
// emitter. Depends on ifmt_pkg, ifmt_req_if, ifmt_chr_if, ifmt_bcd, ifmt_out_stage.
//
//   channel | dir | payload                        | transfer
//   req     | in  | req_type, alt_prefix, value    | valid && ready
//   chr     | out | ascii_char, last_char          | valid && ready
//
// One request at a time; req.ready is high only while the sequencer is idle.
// After the accept, hex, prefix, sign, dot and raw characters are pushed one at a time.
// Decimal: the converter shifts all 32 bits, S_CONV hands off, then S_DEC visits each
// of the 10 digit positions, skipped leading zeros included. Dotted quad: per byte the
// converter shifts 8 bits, S_CONV hands off and S_DEC visits 3 digit positions, with a dot between bytes.
// A stalled chr channel holds the sequencer; reset clears control state only.
module integer_to_ascii_formatter_core
    import ifmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ifmt_req_if.sink   req,
    ifmt_chr_if.source chr
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PFX0 = 4'd1;
    localparam logic [3:0] S_PFX1 = 4'd2;
    localparam logic [3:0] S_HEX  = 4'd3;
    localparam logic [3:0] S_SIGN = 4'd4;
    localparam logic [3:0] S_CONV = 4'd5;
    localparam logic [3:0] S_DEC  = 4'd6;
    localparam logic [3:0] S_DOT  = 4'd7;
    localparam logic [3:0] S_RAW  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  hex_cnt_reg, hex_cnt_next;
    logic [3:0]  rem_reg, rem_next;
    logic        started_reg, started_next;
    logic        quad_mode_reg, quad_mode_next;
    logic [1:0]  byte_reg, byte_next;
    logic [31:0] hex_reg, hex_next;
    logic [23:0] quad_reg, quad_next;

    logic        accept;
    logic [31:0] mag;
    logic        free;
    logic        bcd_busy;
    logic [3:0]  bcd_digit;
    logic [3:0]  bcd_sel;
    logic        last_digit;
    bcd_cmd_t    bcd_cmd;
    out_push_t   push;

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign mag        = req.value[31] ? (32'd0 - req.value) : req.value;
    assign bcd_sel    = rem_reg - 4'd1;
    assign last_digit = (rem_reg == 4'd1) && (!quad_mode_reg || (byte_reg == 2'd3));

    ifmt_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bcd_cmd),
        .sel   (bcd_sel),
        .busy  (bcd_busy),
        .digit (bcd_digit)
    );

    ifmt_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .free  (free),
        .chr   (chr)
    );

    always_comb
    begin
        state_next     = state_reg;
        hex_cnt_next   = hex_cnt_reg;
        rem_next       = rem_reg;
        started_next   = started_reg;
        quad_mode_next = quad_mode_reg;
        byte_next      = byte_reg;
        hex_next       = hex_reg;
        quad_next      = quad_reg;
        bcd_cmd.start  = 1'b0;
        bcd_cmd.bin    = mag;
        bcd_cmd.nbits  = DEC32_BITS;
        push.push      = 1'b0;
        push.ch        = CHAR_ZERO;
        push.last      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_HEX32:
                        begin
                            hex_next     = req.value;
                            hex_cnt_next = 4'd8;
                            state_next   = req.alt_prefix ? S_PFX0 : S_HEX;
                        end
                        REQ_HEX16:
                        begin
                            hex_next     = {req.value[15:0], 16'h0000};
                            hex_cnt_next = 4'd4;
                            state_next   = req.alt_prefix ? S_PFX0 : S_HEX;
                        end
                        REQ_HEX8:
                        begin
                            hex_next     = {req.value[7:0], 24'h000000};
                            hex_cnt_next = 4'd2;
                            state_next   = S_HEX;
                        end
                        REQ_DEC:
                        begin
                            bcd_cmd.start  = 1'b1;
                            quad_mode_next = 1'b0;
                            state_next     = req.value[31] ? S_SIGN : S_CONV;
                        end
                        REQ_RAW:
                        begin
                            hex_next   = req.value;
                            state_next = S_RAW;
                        end
                        REQ_QUAD:
                        begin
                            bcd_cmd.start  = 1'b1;
                            bcd_cmd.bin    = {req.value[7:0], 24'h000000};
                            bcd_cmd.nbits  = DEC8_BITS;
                            quad_next      = req.value[31:8];
                            byte_next      = 2'd0;
                            quad_mode_next = 1'b1;
                            state_next     = S_CONV;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PFX0:
            begin
                if (free)
                begin
                    push.push  = 1'b1;
                    push.ch    = CHAR_ZERO;
                    state_next = S_PFX1;
                end
            end
            S_PFX1:
            begin
                if (free)
                begin
                    push.push  = 1'b1;
                    push.ch    = CHAR_X;
                    state_next = S_HEX;
                end
            end
            S_HEX:
            begin
                if (free)
                begin
                    push.push    = 1'b1;
                    push.ch      = hex_ascii(hex_reg[31:28]);
                    push.last    = (hex_cnt_reg == 4'd1);
                    hex_next     = {hex_reg[27:0], 4'h0};
                    hex_cnt_next = hex_cnt_reg - 4'd1;
                    if (hex_cnt_reg == 4'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SIGN:
            begin
                if (free)
                begin
                    push.push  = 1'b1;
                    push.ch    = CHAR_MINUS;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (!bcd_busy)
                begin
                    rem_next     = quad_mode_reg ? DEC8_DIGITS : DEC32_DIGITS;
                    started_next = 1'b0;
                    state_next   = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!started_reg && (bcd_digit == 4'd0) && (rem_reg != 4'd1))
                begin
                    rem_next = rem_reg - 4'd1;
                end
                else if (free)
                begin
                    push.push    = 1'b1;
                    push.ch      = CHAR_ZERO + {4'h0, bcd_digit};
                    push.last    = last_digit;
                    started_next = 1'b1;
                    rem_next     = rem_reg - 4'd1;
                    if (rem_reg == 4'd1)
                    begin
                        state_next = last_digit ? S_IDLE : S_DOT;
                    end
                end
            end
            S_DOT:
            begin
                if (free)
                begin
                    push.push     = 1'b1;
                    push.ch       = CHAR_DOT;
                    byte_next     = byte_reg + 2'd1;
                    bcd_cmd.start = 1'b1;
                    bcd_cmd.bin   = {quad_reg[7:0], 24'h000000};
                    bcd_cmd.nbits = DEC8_BITS;
                    quad_next     = {8'h00, quad_reg[23:8]};
                    state_next    = S_CONV;
                end
            end
            S_RAW:
            begin
                if (free)
                begin
                    push.push  = 1'b1;
                    push.ch    = hex_reg[7:0];
                    push.last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hex_cnt_reg   <= 4'd0;
            rem_reg       <= 4'd0;
            started_reg   <= 1'b0;
            quad_mode_reg <= 1'b0;
            byte_reg      <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            hex_cnt_reg   <= hex_cnt_next;
            rem_reg       <= rem_next;
            started_reg   <= started_next;
            quad_mode_reg <= quad_mode_next;
            byte_reg      <= byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hex_reg  <= hex_next;
        quad_reg <= quad_next;
    end

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> free)
        else $error("character pushed into a full output register");

    a_dec_idle_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEC) |-> !bcd_busy)
        else $error("digits read while the converter is still shifting");

    a_dec_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEC) |-> (rem_reg != 4'd0))
        else $error("digit emitter entered with no digits left");

    a_conv_started: assert property (@(posedge clk) disable iff (!rst_n)
        bcd_cmd.start |=> bcd_busy)
        else $error("converter failed to start");

endmodule
